/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; each use names its clock, reset and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/adl_pkg.sv */
// Shared constants, types and arithmetic helpers for the audio delay line.
// No dependencies; imported by the interfaces, the top level, the checker, the scoreboard and the testbench.
package adl_pkg;

   localparam int DEPTH    = 1024;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int SAMPLE_W = 16;
   localparam int KIND_W   = 3;
   localparam int FIELD_W  = 10;
   localparam int TAP_W    = (ADDR_W > FIELD_W) ? ADDR_W : FIELD_W;

   // Result queue between the pipeline and the output port.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [KIND_W-1:0]          kind_type;

   localparam kind_type KIND_PUSH     = KIND_W'(0);
   localparam kind_type KIND_TAP      = KIND_W'(1);
   localparam kind_type KIND_MODULATE = KIND_W'(2);
   localparam kind_type KIND_PULL     = KIND_W'(3);
   localparam kind_type KIND_PULL_ADD = KIND_W'(4);

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Q1.15 product, floor shift, saturate.
   function automatic sample_type sat_mul(input sample_type a, input sample_type b);
      logic signed [2*SAMPLE_W-1:0] prod;
      logic signed [2*SAMPLE_W-1:0] shifted;
      prod    = a * b;
      shifted = prod >>> (SAMPLE_W - 1);
      if (shifted > (2*SAMPLE_W)'(SAMPLE_MAX)) begin
         return SAMPLE_MAX;
      end else if (shifted < (2*SAMPLE_W)'(SAMPLE_MIN)) begin
         return SAMPLE_MIN;
      end
      return shifted[SAMPLE_W-1:0];
   endfunction

   function automatic sample_type sat_add(input sample_type a, input sample_type b);
      logic signed [SAMPLE_W:0] sum;
      sum = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
      if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
         return sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
      end
      return sum[SAMPLE_W-1:0];
   endfunction

endpackage

/* rtl/adl_if.sv */
// Request and response channel interfaces for the audio delay line.
// Depends on adl_pkg for field widths.
interface adl_req_if import adl_pkg::*; ();
   logic                valid;
   logic                ready;
   kind_type            kind;
   sample_type          sample_in;
   logic [FIELD_W-1:0]  delay;
   logic [FIELD_W-1:0]  offset;

   modport source (output valid, output kind, output sample_in, output delay,
                   output offset, input ready);
   modport sink   (input valid, input kind, input sample_in, input delay,
                   input offset, output ready);
endinterface

interface adl_rsp_if import adl_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/adl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read of the address being written returns the old contents.
module adl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/audio_delay_line_ring.sv */
// Audio delay line: ring of Q1.15 samples in one RAM with write and read positions.
// Pipeline: an accepted item is registered into stage two; results pass through the result queue.
// Throughput: one item per cycle while ready, set by one RAM read and one RAM write per cycle.
// Reset: synchronous; a clearing pass then zeroes the ring, one entry per cycle,
// through all DEPTH (1024) entries with req_chan.ready low.
module audio_delay_line_ring import adl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   adl_req_if.sink     req_chan,
   adl_rsp_if.source   rsp_chan
);

   // clearing pass
   logic       clear_ff, clear_in;
   addr_type   clear_addr_ff, clear_addr_in;

   // positions
   addr_type   wr_pos_ff, wr_pos_in;
   addr_type   rd_pos_ff, rd_pos_in;

   // second stage
   logic       b_valid_ff, b_valid_in;
   kind_type   b_kind_ff;
   addr_type   b_addr_ff;
   sample_type b_sample_ff;
   logic       fwd_hit_ff, fwd_hit_in;
   sample_type fwd_data_ff;

   // result queue
   sample_type             fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;

   logic                   req_accept;
   logic                   rsp_pop;
   addr_type               a_addr;
   logic [TAP_W-1:0]       tap_full;
   addr_type               wr_pos_next;
   addr_type               rd_pos_next;
   sample_type             ram_rd_data;
   sample_type             cur;
   logic                   b_wr;
   sample_type             b_wr_data;
   logic                   b_res;
   sample_type             res_data;
   logic                   ram_wr_en;
   addr_type               ram_wr_addr;
   sample_type             ram_wr_data;

   assign req_accept  = req_chan.valid && req_chan.ready;
   assign rsp_pop     = rsp_chan.valid && rsp_chan.ready;

   assign wr_pos_next = wr_pos_ff + ADDR_W'(1);
   assign rd_pos_next = rd_pos_ff + ADDR_W'(1);
   assign tap_full    = TAP_W'(wr_pos_ff) - TAP_W'(req_chan.delay) + TAP_W'(req_chan.offset);

   always_comb begin
      case (req_chan.kind)
         KIND_PUSH:                a_addr = wr_pos_next;
         KIND_PULL, KIND_PULL_ADD: a_addr = rd_pos_next;
         default:                  a_addr = tap_full[ADDR_W-1:0];
      endcase
   end

   assign wr_pos_in = (req_accept && req_chan.kind == KIND_PUSH) ? wr_pos_next : wr_pos_ff;
   assign rd_pos_in = (req_accept && (req_chan.kind == KIND_PULL ||
                                      req_chan.kind == KIND_PULL_ADD)) ? rd_pos_next
                                                                        : rd_pos_ff;

   // Stage two sees the RAM data, patched with the write of the item just ahead.
   assign cur       = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign b_wr      = b_valid_ff && (b_kind_ff == KIND_PUSH || b_kind_ff == KIND_MODULATE);
   assign b_wr_data = (b_kind_ff == KIND_PUSH) ? b_sample_ff : sat_mul(cur, b_sample_ff);
   assign b_res     = b_valid_ff && (b_kind_ff == KIND_TAP || b_kind_ff == KIND_PULL ||
                                     b_kind_ff == KIND_PULL_ADD);
   assign res_data  = (b_kind_ff == KIND_PULL_ADD) ? sat_add(cur, b_sample_ff) : cur;

   assign fwd_hit_in = b_wr && (b_addr_ff == a_addr);
   assign b_valid_in = req_accept;

   assign ram_wr_en   = clear_ff || b_wr;
   assign ram_wr_addr = clear_ff ? clear_addr_ff : b_addr_ff;
   assign ram_wr_data = clear_ff ? '0 : b_wr_data;

   adl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (a_addr),
      .rd_data (ram_rd_data)
   );

   assign clear_in      = clear_ff && (clear_addr_ff != ADDR_W'(DEPTH - 1));
   assign clear_addr_in = clear_ff ? clear_addr_ff + ADDR_W'(1) : clear_addr_ff;

   // Queue bookkeeping
   assign tail_in  = b_res ? tail_ff + RSP_PTR_W'(1) : tail_ff;
   assign head_in  = rsp_pop ? head_ff + RSP_PTR_W'(1) : head_ff;
   assign count_in = count_ff + RSP_CNT_W'(b_res) - RSP_CNT_W'(rsp_pop);

   // Leave room for the item in flight and the one being accepted.
   assign req_chan.ready = !clear_ff &&
                           ((count_ff + RSP_CNT_W'(b_res)) <= RSP_CNT_W'(RSP_DEPTH - 2));

   assign rsp_chan.valid      = (count_ff != '0);
   assign rsp_chan.sample_out = fifo_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         wr_pos_ff     <= '0;
         rd_pos_ff     <= '0;
         b_valid_ff    <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         wr_pos_ff     <= wr_pos_in;
         rd_pos_ff     <= rd_pos_in;
         b_valid_ff    <= b_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      b_kind_ff   <= req_chan.kind;
      b_addr_ff   <= a_addr;
      b_sample_ff <= req_chan.sample_in;
      fwd_data_ff <= b_wr_data;
      if (b_res) begin
         fifo_ff[tail_ff] <= res_data;
      end
   end

endmodule

/* rtl/adl_checker.sv */
// Port-level checks for the audio delay line, bound to the top level.
// Depends on adl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module adl_checker import adl_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input kind_type req_kind,
   input logic     rsp_valid,
   input logic     rsp_ready
);

   logic req_has_result;

   assign req_has_result = req_valid && req_ready &&
                           (req_kind == KIND_TAP || req_kind == KIND_PULL ||
                            req_kind == KIND_PULL_ADD);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `ASSERT_IMPLY(a_clear_blocks, clock, reset, $past(reset), !req_ready, "ready during clearing pass")
   `ASSERT_IMPLY(a_no_early_rsp, clock, reset, $past(reset), !rsp_valid, "rsp right after reset")
   `ASSERT_IMPLY(a_rsp_follows, clock, reset, req_has_result, ##2 rsp_valid, "result item missing")

endmodule

bind audio_delay_line_ring adl_checker u_adl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_kind  (req_chan.kind),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

/* dv/delay_line_board_pkg.sv */
// Scoreboard for the audio delay line: keeps its own copy of the sample ring
// and both positions, predicts each result and checks the block's output.
// Depends on adl_pkg for widths, sample type and item kind codes.
package delay_line_board_pkg;
   import adl_pkg::*;

   class delay_line_board;
      sample_type ring [DEPTH];
      addr_type   wr_pos;
      addr_type   rd_pos;
      sample_type expected_samples [$];
      int         errors;
      int         checked;
      int         kind_count [8];

      function new();
         foreach (ring[i]) ring[i] = '0;
         wr_pos  = '0;
         rd_pos  = '0;
         errors  = 0;
         checked = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      // Clamp a wide value into the sample range.
      function sample_type clamp(input longint v);
         if (v > longint'(SAMPLE_MAX)) begin
            return SAMPLE_MAX;
         end else if (v < longint'(SAMPLE_MIN)) begin
            return SAMPLE_MIN;
         end
         return sample_type'(v);
      endfunction

      function void note_request(input kind_type k, input sample_type s,
                                 input logic [FIELD_W-1:0] d,
                                 input logic [FIELD_W-1:0] o);
         addr_type tap;
         longint   prod;
         tap = wr_pos - addr_type'(d) + addr_type'(o);
         kind_count[k]++;
         case (k)
            KIND_PUSH: begin
               wr_pos       = wr_pos + 1'b1;
               ring[wr_pos] = s;
            end
            KIND_TAP: begin
               expected_samples.push_back(ring[tap]);
            end
            KIND_MODULATE: begin
               // floor shift: arithmetic shift of the full product
               prod      = longint'(ring[tap]) * longint'(s);
               ring[tap] = clamp(prod >>> (SAMPLE_W - 1));
            end
            KIND_PULL: begin
               rd_pos = rd_pos + 1'b1;
               expected_samples.push_back(ring[rd_pos]);
            end
            KIND_PULL_ADD: begin
               rd_pos = rd_pos + 1'b1;
               expected_samples.push_back(clamp(longint'(ring[rd_pos]) + longint'(s)));
            end
            default: begin
            end
         endcase
      endfunction

      function void check_sample(input sample_type actual, input realtime stamp);
         sample_type want;
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0.1f ns: unexpected result, expected none, actual %0d",
                     stamp, actual);
            return;
         end
         want = expected_samples.pop_front();
         checked++;
         if (actual !== want) begin
            errors++;
            $display("%0.1f ns: sample_out mismatch, expected %0d, actual %0d",
                     stamp, want, actual);
         end
      endfunction
   endclass

endpackage

/* dv/tb_top.sv */
// Top-level testbench for audio_delay_line_ring: directed corner items, then
// random streams with random idling on both channels, checked by a scoreboard.
// Depends on adl_pkg, the channel interfaces and delay_line_board_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import adl_pkg::*;
   import delay_line_board_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int STALL_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 8;

   logic clock;
   logic reset;
   int   quiet_cycles;

   delay_line_board board;

   adl_req_if req_chan ();
   adl_rsp_if rsp_chan ();

   audio_delay_line_ring u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return SAMPLE_MAX;
      if (r == 1) return SAMPLE_MIN;
      if (r == 2) return sample_type'($urandom_range(0, 15) - 8);
      return sample_type'($urandom);
   endfunction

   function automatic logic [FIELD_W-1:0] pick_field();
      if ($urandom_range(0, 3) < 2) return FIELD_W'($urandom_range(0, 15));
      return FIELD_W'($urandom_range(0, 1023));
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input kind_type k, input sample_type s,
                            input logic [FIELD_W-1:0] d,
                            input logic [FIELD_W-1:0] o);
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= k;
      req_chan.sample_in <= s;
      req_chan.delay     <= d;
      req_chan.offset    <= o;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic idle_sender(input int n);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_spaced(input kind_type k, input sample_type s,
                              input logic [FIELD_W-1:0] d,
                              input logic [FIELD_W-1:0] o);
      send_item(k, s, d, o);
      idle_sender(pick_gap());
   endtask

   // Let the clock advance first so the monitor has noted the last accepted item.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Receiver: ready stretches broken by stalls, mostly short.
   initial begin
      int run;
      int stall;
      @(negedge reset);
      @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
         repeat (run) @(posedge clock);
         stall = $urandom_range(0, 9) == 0 ? $urandom_range(20, 50) : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Monitor both channels and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            board.note_request(req_chan.kind, req_chan.sample_in,
                               req_chan.delay, req_chan.offset);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_sample(rsp_chan.sample_out, $realtime);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int         useful;
      int         burst_left;
      bit         paused;
      int         r;
      kind_type   k;
      sample_type s;

      board              = new();
      quiet_cycles       = 0;
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_PUSH;
      req_chan.sample_in = '0;
      req_chan.delay     = '0;
      req_chan.offset    = '0;
      rsp_chan.ready     = 1'b0;
      useful             = 0;
      burst_left         = 0;
      paused             = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed corners: full-scale samples, wrapped taps, saturation, unused kind codes.
      send_spaced(KIND_PUSH, SAMPLE_MAX, 10'h3ff, 10'h3ff);
      send_spaced(KIND_PUSH, SAMPLE_MIN, 10'h155, 10'h2aa);
      send_spaced(KIND_PUSH, 16'sh5a5a, 10'h000, 10'h000);
      send_spaced(KIND_TAP, 16'sh7fff, 10'd0, 10'd0);
      send_spaced(KIND_TAP, '0, 10'd2, 10'd0);
      send_spaced(KIND_TAP, '0, 10'd1023, 10'd1023);
      send_spaced(KIND_TAP, SAMPLE_MIN, 10'd1023, 10'd0);
      send_spaced(KIND_MODULATE, SAMPLE_MIN, 10'd1, 10'd0);
      send_spaced(KIND_TAP, '0, 10'd1, 10'd0);
      send_spaced(KIND_MODULATE, SAMPLE_MIN, 10'd2, 10'd0);
      send_spaced(KIND_TAP, '0, 10'd2, 10'd0);
      send_spaced(KIND_MODULATE, 16'shffff, 10'd0, 10'd0);
      send_spaced(KIND_TAP, '0, 10'd5, 10'd5);
      send_spaced(kind_type'(5), SAMPLE_MAX, 10'h3ff, 10'h3ff);
      send_spaced(kind_type'(6), SAMPLE_MIN, 10'h2aa, 10'h155);
      send_spaced(kind_type'(7), 16'sh1234, 10'd7, 10'd9);
      send_spaced(KIND_PULL, SAMPLE_MIN, 10'h3ff, 10'h3ff);
      send_spaced(KIND_PULL_ADD, SAMPLE_MAX, 10'd3, 10'd1);
      send_spaced(KIND_PULL_ADD, SAMPLE_MIN, 10'd0, 10'd0);
      send_spaced(KIND_PULL, '0, 10'd0, 10'd0);
      send_spaced(KIND_TAP, '0, 10'd512, 10'd3);

      while (useful < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 35) k = KIND_PUSH;
         else if (r < 55) k = KIND_TAP;
         else if (r < 65) k = KIND_MODULATE;
         else if (r < 80) k = KIND_PULL;
         else if (r < 95) k = KIND_PULL_ADD;
         else k = kind_type'($urandom_range(5, 7));
         s = pick_sample();
         send_item(k, s, pick_field(), pick_field());
         if (k <= KIND_PULL_ADD) useful++;

         if (!paused && useful >= RANDOM_ITEMS / 2) begin
            // hold the sender until the block has drained every result
            paused = 1'b1;
            wait_for_results();
         end else if (burst_left > 0) begin
            burst_left--;
         end else begin
            if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
            idle_sender(pick_gap());
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Items: %0d push, %0d tap, %0d modulate, %0d pull, %0d pull-add, %0d ignored",
               board.kind_count[KIND_PUSH], board.kind_count[KIND_TAP],
               board.kind_count[KIND_MODULATE], board.kind_count[KIND_PULL],
               board.kind_count[KIND_PULL_ADD],
               board.kind_count[5] + board.kind_count[6] + board.kind_count[7]);
      $display("Results checked: %0d, mismatches: %0d", board.checked, board.errors);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/adl_pkg.sv
rtl/adl_if.sv
rtl/adl_ram.sv
rtl/audio_delay_line_ring.sv
rtl/adl_checker.sv
dv/delay_line_board_pkg.sv
dv/tb_top.sv
